// ----- rtl/smf_pkg.sv -----
// shared types and constants for the sliding median filter
package smf_pkg;

   localparam int CFG_W = 4;
   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 4'd5;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FIND = 4'b0010,
      ST_SORT = 4'b0100,
      ST_MED  = 4'b1000
   } state_type;

endpackage

// ----- rtl/smf_ifs.sv -----
// valid/ready channel interfaces for sample, median and window length words
interface smf_sample_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface smf_median_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink (input valid, input median, output ready);
endinterface

interface smf_cfg_if;
   logic                         valid;
   logic                         ready;
   logic [smf_pkg::CFG_W-1:0]    window_length;

   modport source (output valid, output window_length, input ready);
   modport sink (input valid, input window_length, output ready);
endinterface

// ----- rtl/smf_ram.sv -----
// generic single write port ram with registered read
module smf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sliding_median_filter_top.sv -----
// sliding window median filter top level with sorted window and sequencer
// steps: accept a sample, search the sorted window for the word that leaves (full window only),
// insert the new word by compare and swap, then offer the median word once the window is full
// a new sample is taken only in the idle state, after the previous one is through; one compare per cycle
// reset: window empty, length 5, result channel empty; no clearing pass
module sliding_median_filter_top #(
   parameter int MAX_WINDOW  = 15,
   parameter int SAMPLE_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   smf_sample_if.sink req_chan,
   smf_median_if.source rsp_chan,
   smf_cfg_if.sink    csr_chan
);

   localparam int IDX_W   = $clog2(MAX_WINDOW);
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int LW      = (CNT_W > smf_pkg::CFG_W) ? CNT_W : smf_pkg::CFG_W;
   localparam int LEN_CAP = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

   smf_pkg::state_type state_ff, state_in;

   logic [smf_pkg::CFG_W-1:0]     wl_ff, wl_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic [IDX_W-1:0]              oldest_ff, oldest_in;
   logic [IDX_W-1:0]              k_ff, k_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic                          down_ff, down_in;
   logic signed [SAMPLE_BITS-1:0] new_ff, new_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;

   logic signed [SAMPLE_BITS-1:0] srt_ff [MAX_WINDOW];
   logic                          srt_we;
   logic [IDX_W-1:0]              srt_waddr;
   logic signed [SAMPLE_BITS-1:0] srt_wdata;
   logic [IDX_W-1:0]              rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_data;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [SAMPLE_BITS-1:0]        ram_wdata;
   logic                          ram_re;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [SAMPLE_BITS-1:0] old_key;

   logic [LW-1:0]    len_raw;
   logic [LW-1:0]    len_w;
   logic [CNT_W-1:0] len;
   logic [IDX_W-1:0] half;
   logic [IDX_W-1:0] last;
   logic             full;
   logic             at_edge;
   logic             swap;
   logic [IDX_W-1:0] q_idx;
   logic [CNT_W-1:0] fill_next;

   // effective odd length, capped to storage
   assign len_raw = LW'(wl_ff) | LW'(1);
   assign len_w   = (len_raw > LW'(LEN_CAP)) ? LW'(LEN_CAP) : len_raw;
   assign len     = CNT_W'(len_w);
   assign half    = IDX_W'(len >> 1);
   assign last    = IDX_W'(len - CNT_W'(1));
   assign full    = (fill_ff == len);
   assign fill_next = fill_ff + CNT_W'(1);
   assign old_key = $signed(ram_rdata);

   assign rd_data = srt_ff[rd_addr];

   // neighbor of the moving word inside the sorted window
   assign at_edge = down_ff ? (pos_ff == '0) : (pos_ff == last);
   assign q_idx   = at_edge ? pos_ff : (down_ff ? pos_ff - IDX_W'(1) : pos_ff + IDX_W'(1));

   assign req_chan.ready = (state_ff == smf_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.median = rsp_median_ff;

   smf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (oldest_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      wl_in         = wl_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      down_in       = down_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_median_in = rsp_median_ff;
      srt_we        = 1'b0;
      srt_waddr     = pos_ff;
      srt_wdata     = new_ff;
      rd_addr       = k_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = new_ff;
      ram_re        = 1'b0;
      swap          = 1'b0;

      case (state_ff)
         smf_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               new_in = req_chan.sample;
               if (full) begin
                  // fetch the word that leaves the window
                  ram_re   = 1'b1;
                  slot_in  = oldest_ff;
                  k_in     = '0;
                  state_in = smf_pkg::ST_FIND;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(fill_ff);
                  ram_wdata = req_chan.sample;
                  pos_in    = IDX_W'(fill_ff);
                  down_in   = 1'b1;
                  state_in  = smf_pkg::ST_SORT;
               end
            end
         end
         smf_pkg::ST_FIND: begin
            rd_addr = k_ff;
            if (rd_data == old_key) begin
               pos_in   = k_ff;
               down_in  = (new_ff < old_key);
               ram_we   = 1'b1;
               state_in = smf_pkg::ST_SORT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         smf_pkg::ST_SORT: begin
            rd_addr = q_idx;
            swap    = !at_edge && (down_ff ? (rd_data > new_ff) : (rd_data < new_ff));
            srt_we  = 1'b1;
            if (swap) begin
               srt_wdata = rd_data;
               pos_in    = q_idx;
            end else begin
               srt_wdata = new_ff;
               if (!full) begin
                  fill_in = fill_next;
                  if (fill_next == len) begin
                     oldest_in = '0;
                     state_in  = smf_pkg::ST_MED;
                  end else begin
                     state_in = smf_pkg::ST_IDLE;
                  end
               end else begin
                  oldest_in = (oldest_ff == last) ? '0 : oldest_ff + IDX_W'(1);
                  state_in  = smf_pkg::ST_MED;
               end
            end
         end
         smf_pkg::ST_MED: begin
            rd_addr = half;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_median_in = rd_data;
               rsp_valid_in  = 1'b1;
               state_in      = smf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smf_pkg::ST_IDLE;
         end
      endcase

      // length write empties the window
      if (csr_chan.valid) begin
         wl_in     = csr_chan.window_length;
         fill_in   = '0;
         oldest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smf_pkg::ST_IDLE;
         wl_ff        <= smf_pkg::WINDOW_LENGTH_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      down_ff       <= down_in;
      new_ff        <= new_in;
      rsp_median_ff <= rsp_median_in;
      if (srt_we) begin
         srt_ff[srt_waddr] <= srt_wdata;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len)
      else $error("fill count beyond window length");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      full |-> (CNT_W'(oldest_ff) < len))
      else $error("oldest slot outside window");

   a_find_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smf_pkg::ST_FIND) |-> (CNT_W'(k_ff) < len))
      else $error("leaving word not found in sorted window");

   a_sort_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smf_pkg::ST_SORT) |-> (CNT_W'(pos_ff) < len))
      else $error("insert position outside window");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == smf_pkg::ST_MED))
      else $error("median word raised outside output step");
`endif

endmodule

// ----- verif/smf_median_checker.sv -----
// checker that predicts median words from accepted samples and compares the result channel
module smf_median_checker #(
   parameter int MAX_WINDOW  = 15,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_median,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [smf_pkg::CFG_W-1:0]     csr_window_length,
   output int                            fail_count,
   output int                            expected_count
);

   localparam int unsigned PRED_DEPTH = 16;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   sample_type                window [MAX_WINDOW];
   int unsigned               fill_count;
   int unsigned               oldest_slot;
   logic [smf_pkg::CFG_W-1:0] window_length;
   sample_type                pred_mem [PRED_DEPTH];
   int unsigned               pred_wr;
   int unsigned               pred_rd;
   int unsigned               pred_count;

   function automatic int unsigned span_of(input logic [smf_pkg::CFG_W-1:0] setting);
      int unsigned len;
      int unsigned cap;
      len = setting;
      cap = MAX_WINDOW;
      if (len % 2 == 0) len++;
      if (cap % 2 == 0) cap--;
      return (len > cap) ? cap : len;
   endfunction

   function automatic sample_type window_median(input int unsigned len);
      sample_type  sorted [MAX_WINDOW];
      sample_type  word;
      int unsigned j;
      for (int unsigned i = 0; i < len; i++) begin
         word = window[i];
         j = i;
         while (j > 0 && sorted[j-1] > word) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = word;
      end
      return sorted[len/2];
   endfunction

   function automatic void stash_median(input sample_type value);
      if (pred_count == PRED_DEPTH) begin
         fail_count++;
         if (fail_count <= 10)
            $display("too many median words outstanding: dropped expected %0d", value);
      end else begin
         pred_mem[pred_wr] = value;
         pred_wr = (pred_wr + 1) % PRED_DEPTH;
         pred_count++;
      end
   endfunction

   always @(posedge clock) begin : predict_and_compare
      int unsigned len;
      sample_type  got;
      sample_type  want;
      if (reset) begin
         window_length = smf_pkg::WINDOW_LENGTH_RESET;
         fill_count    = 0;
         oldest_slot   = 0;
         pred_wr       = 0;
         pred_rd       = 0;
         pred_count    = 0;
         fail_count    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_length = csr_window_length;
            fill_count    = 0;
            oldest_slot   = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_median;
            if (pred_count == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("median word with none expected: got %0d", got);
            end else begin
               want = pred_mem[pred_rd];
               pred_rd = (pred_rd + 1) % PRED_DEPTH;
               pred_count--;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("median mismatch: expected %0d, got %0d", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            len = span_of(window_length);
            if (fill_count < len) begin
               window[fill_count] = req_sample;
               fill_count++;
               if (fill_count == len) begin
                  oldest_slot = 0;
                  stash_median(window_median(len));
               end
            end else begin
               if (oldest_slot >= len) oldest_slot = 0;
               window[oldest_slot] = req_sample;
               oldest_slot++;
               if (oldest_slot >= len) oldest_slot = 0;
               stash_median(window_median(len));
            end
         end
      end
      expected_count = int'(pred_count);
   end

endmodule

// ----- verif/sliding_median_filter_top_tb.sv -----
// testbench top for the sliding median filter: sample and length stimulus, verdict
module sliding_median_filter_top_tb;

   localparam int MAX_WINDOW    = 15;
   localparam int SAMPLE_BITS   = 16;
   localparam int SETTLE_CYCLES = 2 * MAX_WINDOW + 10;
   localparam int HOLD_CYCLES   = 400;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset;
   logic hold_off;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   fail_count;
   int   expected_count;

   smf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   smf_median_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();
   smf_cfg_if                                 csr_if ();

   sliding_median_filter_top #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   smf_median_checker #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_sample       (req_if.sample),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_median       (rsp_if.median),
      .csr_valid        (csr_if.valid),
      .csr_ready        (csr_if.ready),
      .csr_window_length(csr_if.window_length),
      .fail_count       (fail_count),
      .expected_count   (expected_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_off)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   task automatic push_sample(input sample_type value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= value;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_length(input logic [smf_pkg::CFG_W-1:0] setting);
      csr_if.valid         <= 1'b1;
      csr_if.window_length <= setting;
      @(negedge clock);
      while (!csr_if.ready) @(negedge clock);
      @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      wait (expected_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(3, 0))
         0: return sample_type'($urandom_range(8, 0) - 4);
         1: return $urandom_range(1, 0) ? SAMPLE_MAX : SAMPLE_MIN;
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int unsigned               phase;
      logic [smf_pkg::CFG_W-1:0] setting;
      logic [smf_pkg::CFG_W-1:0] length_corners [4];
      length_corners = '{4'd15, 4'd0, 4'd14, 4'd1};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset                <= 1'b1;
      hold_off             <= 1'b0;
      req_if.valid         <= 1'b0;
      req_if.sample        <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.window_length <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset length of five, field extremes and ties
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(sample_type'(0));
      push_sample(sample_type'(-1));
      push_sample(sample_type'(1));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);

      // zero length acts as a window of one
      drain();
      write_length(4'd0);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(sample_type'('h5555));
      push_sample(sample_type'('hAAAA));

      // a length write empties a partly filled window
      drain();
      write_length(4'd2);
      push_sample(sample_type'(100));
      push_sample(sample_type'(-100));
      drain();
      write_length(4'd2);
      push_sample(sample_type'(7));
      push_sample(sample_type'(-7));
      push_sample(sample_type'(0));

      for (phase = 0; phase < 12; phase++) begin
         drain();
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 77;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 77;
            end
            default: begin
               send_idle_pct = 14;
               rsp_stall_pct = 14;
            end
         endcase
         setting = (phase < 4) ? length_corners[phase[1:0]] :
                                 smf_pkg::CFG_W'($urandom_range(15, 0));
         write_length(setting);
         if (phase == 0) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         repeat ($urandom_range(44, 30)) push_sample(random_sample());
      end

      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
